>>> rtl/core/bilinear_sample_blend_defines.svh
// Assertion macros used by the checker of the sampler block.
`ifndef BILINEAR_SAMPLE_BLEND_DEFINES_SVH
`define BILINEAR_SAMPLE_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSB_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

// Condition that holds at every edge, reset included.
`define BSB_ASSERT_ALWAYS(lbl, clk, cond, msg) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error(msg);

`endif

>>> rtl/core/bsb_pkg.sv
package bsb_pkg;

	localparam int ChanW    = 8;
	localparam int NumChan  = 4;
	localparam int CoordW   = 24;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 9;

	// item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// register map
	typedef enum logic [CfgIdxW-1:0] {
		REG_BLEND_WEIGHT   = 3'd0,
		REG_CHANNEL_ENABLE = 3'd1,
		REG_INTERPOLATE    = 3'd2,
		REG_ALPHA_ENABLE   = 3'd3,
		REG_IMAGE_WIDTH    = 3'd4,
		REG_IMAGE_HEIGHT   = 3'd5
	} cfg_reg_t;

	// one stored texel; channel c sits at bits 8c+7:8c (blue, green, red, alpha)
	typedef struct packed {
		logic [ChanW-1:0] alpha;
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} texel_t;

	typedef struct packed {
		logic                     kind;
		logic [ChanW-1:0]         pos_x;
		logic [ChanW-1:0]         pos_y;
		logic signed [CoordW-1:0] sample_x;
		logic signed [CoordW-1:0] sample_y;
		logic [ChanW-1:0]         red_in;
		logic [ChanW-1:0]         green_in;
		logic [ChanW-1:0]         blue_in;
		logic [ChanW-1:0]         alpha_in;
	} item_t;

	typedef struct packed {
		logic [ChanW-1:0] dest_x;
		logic [ChanW-1:0] dest_y;
		logic [ChanW-1:0] red_out;
		logic [ChanW-1:0] green_out;
		logic [ChanW-1:0] blue_out;
		logic [ChanW-1:0] alpha_out;
		logic             changed;
	} result_t;

	// per-sample data that rides along with the texels
	typedef struct packed {
		logic             changed;
		logic [ChanW-1:0] dest_x;
		logic [ChanW-1:0] dest_y;
		texel_t           dst;
	} side_t;

	// channel enables for the blend stage
	typedef struct packed {
		logic [2:0] chan_en;
		logic       alpha_en;
	} blend_ctl_t;

	function automatic logic [ChanW-1:0] chan_of(texel_t t, int c);
		logic [NumChan*ChanW-1:0] w;
		w = t;
		return w[ChanW*c +: ChanW];
	endfunction

endpackage

>>> rtl/core/bsb_stream_if.sv
interface bsb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/bsb_fetch.sv
module bsb_fetch #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS = 8,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bsb_stream_if.sink             items,
	input  logic [XW-1:0]          x_last,
	input  logic [YW-1:0]          y_last,
	input  logic                   interp,
	output logic                   hand_valid,
	input  logic                   hand_ready,
	output bsb_pkg::texel_t [3:0]  hand_tex,
	output logic [FRAC_BITS-1:0]   hand_fx,
	output logic [FRAC_BITS-1:0]   hand_fy,
	output bsb_pkg::side_t         hand_side
);
	import bsb_pkg::*;

	localparam int AW    = XW + YW;
	localparam int PXW   = XW + FRAC_BITS;
	localparam int PYW   = YW + FRAC_BITS;
	localparam int Depth = 1 << AW;

	typedef struct packed {
		logic           kind;
		logic           near;
		logic [PXW-1:0] cx;
		logic [PYW-1:0] cy;
		logic [7:0]     pos_x;
		logic [7:0]     pos_y;
		texel_t         pix;
	} work_t;

	work_t                item_q;
	logic                 busy_q;
	logic [1:0]           step_q;

	logic                 r_valid_q;
	logic [1:0]           r_slot_q;
	logic                 r_last_q;
	logic                 r_near_q;
	logic [FRAC_BITS-1:0] r_fx_q;
	logic [FRAC_BITS-1:0] r_fy_q;
	side_t                r_side_q;
	texel_t               tex_q [3];
	texel_t               rdata_q;

	texel_t               mem [Depth];

	logic [PXW-1:0]       x_top;
	logic [PYW-1:0]       y_top;
	logic [PXW-1:0]       cx_in;
	logic [PYW-1:0]       cy_in;
	logic [XW-1:0]        x0, x1, nx;
	logic [YW-1:0]        y0, y1, ny;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [AW-1:0]        mem_addr;
	logic                 in_range;
	logic                 last_step;
	logic                 adv;
	logic                 mem_we;
	logic                 mem_re;
	logic                 accept;
	logic                 changed;

	// clamp the source position to the image in use
	assign x_top = {x_last, {FRAC_BITS{1'b0}}};
	assign y_top = {y_last, {FRAC_BITS{1'b0}}};

	always_comb begin
		if (items.data.sample_x[CoordW-1]) begin
			cx_in = '0;
		end else if (32'(items.data.sample_x[CoordW-2:0]) > 32'(x_top)) begin
			cx_in = x_top;
		end else begin
			cx_in = PXW'(items.data.sample_x[CoordW-2:0]);
		end
		if (items.data.sample_y[CoordW-1]) begin
			cy_in = '0;
		end else if (32'(items.data.sample_y[CoordW-2:0]) > 32'(y_top)) begin
			cy_in = y_top;
		end else begin
			cy_in = PYW'(items.data.sample_y[CoordW-2:0]);
		end
	end

	// neighbors with edge replication; nearest rounds half up
	assign x0 = item_q.cx[PXW-1:FRAC_BITS];
	assign y0 = item_q.cy[PYW-1:FRAC_BITS];
	assign fx = item_q.cx[FRAC_BITS-1:0];
	assign fy = item_q.cy[FRAC_BITS-1:0];
	assign x1 = (x0 == x_last) ? x0 : XW'(x0 + 1'b1);
	assign y1 = (y0 == y_last) ? y0 : YW'(y0 + 1'b1);
	assign nx = fx[FRAC_BITS-1] ? x1 : x0;
	assign ny = fy[FRAC_BITS-1] ? y1 : y0;
	assign changed = !item_q.near || (nx != '0) || (ny != '0);

	// memory address of the current step
	always_comb begin
		if (item_q.kind == KIND_LOAD) begin
			mem_addr = {YW'(item_q.pos_y), XW'(item_q.pos_x)};
		end else if (item_q.near) begin
			mem_addr = {ny, nx};
		end else begin
			unique case (step_q)
				2'd0:    mem_addr = {y0, x0};
				2'd1:    mem_addr = {y0, x1};
				2'd2:    mem_addr = {y1, x0};
				default: mem_addr = {y1, x1};
			endcase
		end
	end

	assign in_range  = (32'(item_q.pos_x) < MAX_WIDTH) && (32'(item_q.pos_y) < MAX_HEIGHT);
	assign last_step = (item_q.kind == KIND_LOAD) || item_q.near || (step_q == 2'd3);

	// the front freezes while a finished texel set waits for the lerp pipe
	assign hand_valid = r_valid_q && r_last_q;
	assign adv        = !hand_valid || hand_ready;
	assign mem_we     = busy_q && adv && (item_q.kind == KIND_LOAD) && in_range;
	assign mem_re     = busy_q && adv && (item_q.kind == KIND_SAMPLE);
	assign items.ready = !busy_q || (adv && last_step);
	assign accept     = items.valid && items.ready;

	// sequencer and read-response control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= 2'd0;
			r_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q && adv && last_step) begin
				busy_q <= 1'b0;
			end else if (busy_q && adv) begin
				step_q <= step_q + 2'd1;
			end
			if (adv) begin
				r_valid_q <= mem_re;
			end
		end
	end

	// item and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.kind  <= items.data.kind;
			item_q.near  <= !interp;
			item_q.cx    <= cx_in;
			item_q.cy    <= cy_in;
			item_q.pos_x <= items.data.pos_x;
			item_q.pos_y <= items.data.pos_y;
			item_q.pix   <= {items.data.alpha_in, items.data.red_in,
				items.data.green_in, items.data.blue_in};
		end
		if (mem_re) begin
			r_slot_q         <= step_q;
			r_last_q         <= last_step;
			r_near_q         <= item_q.near;
			r_fx_q           <= fx;
			r_fy_q           <= fy;
			r_side_q.changed <= changed;
			r_side_q.dest_x  <= item_q.pos_x;
			r_side_q.dest_y  <= item_q.pos_y;
			r_side_q.dst     <= item_q.pix;
		end
		if (adv && r_valid_q && !r_last_q) begin
			tex_q[r_slot_q] <= rdata_q;
		end
	end

	// source image store, one port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= item_q.pix;
		end else if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// nearest: the one texel stands for all four, fractions zero
	assign hand_tex  = r_near_q ? {4{rdata_q}} : {rdata_q, tex_q[2], tex_q[1], tex_q[0]};
	assign hand_fx   = r_near_q ? '0 : r_fx_q;
	assign hand_fy   = r_near_q ? '0 : r_fy_q;
	assign hand_side = r_side_q;

endmodule

>>> rtl/core/bsb_lerp.sv
module bsb_lerp #(
	parameter int FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hand_valid,
	output logic                  hand_ready,
	input  bsb_pkg::texel_t [3:0] hand_tex,
	input  logic [FRAC_BITS-1:0]  hand_fx,
	input  logic [FRAC_BITS-1:0]  hand_fy,
	input  bsb_pkg::side_t        hand_side,
	output logic                  samp_valid,
	input  logic                  samp_ready,
	output bsb_pkg::texel_t       samp,
	output bsb_pkg::side_t        samp_side
);
	import bsb_pkg::*;

	localparam int HW = ChanW + FRAC_BITS;
	localparam int VW = 2 * FRAC_BITS + 10;
	localparam logic signed [VW-1:0] RoundC =
		{{(VW-2*FRAC_BITS){1'b0}}, 1'b1, {(2*FRAC_BITS-1){1'b0}}};

	logic                 v_s1, v_s2, v_s3;
	texel_t [3:0]         tex_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1, fy_s2;
	side_t                side_s1, side_s2, side_s3;
	logic [HW-1:0]        top_s2 [NumChan];
	logic [HW-1:0]        bot_s2 [NumChan];
	texel_t               samp_s3;

	logic signed [ChanW:0] dt [NumChan];
	logic signed [ChanW:0] db [NumChan];
	logic signed [HW+1:0]  top_w [NumChan];
	logic signed [HW+1:0]  bot_w [NumChan];
	logic signed [HW:0]    dv [NumChan];
	logic signed [VW-1:0]  v_w [NumChan];
	logic [NumChan*ChanW-1:0] samp_w;
	logic                  en1, en2, en3;

	assign en3 = !v_s3 || samp_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign hand_ready = en1;

	// horizontal lerp: p0*S + (p1-p0)*fx on the top and bottom rows
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			dt[c] = $signed({1'b0, chan_of(tex_s1[1], c)}) - $signed({1'b0, chan_of(tex_s1[0], c)});
			db[c] = $signed({1'b0, chan_of(tex_s1[3], c)}) - $signed({1'b0, chan_of(tex_s1[2], c)});
			top_w[c] = $signed({2'b00, chan_of(tex_s1[0], c), {FRAC_BITS{1'b0}}})
				+ dt[c] * $signed({1'b0, fx_s1});
			bot_w[c] = $signed({2'b00, chan_of(tex_s1[2], c), {FRAC_BITS{1'b0}}})
				+ db[c] * $signed({1'b0, fx_s1});
		end
	end

	// vertical lerp, round half up, drop both fractions
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			dv[c] = $signed({1'b0, bot_s2[c]}) - $signed({1'b0, top_s2[c]});
			v_w[c] = $signed({2'b00, top_s2[c], {FRAC_BITS{1'b0}}})
				+ dv[c] * $signed({1'b0, fy_s2}) + RoundC;
			samp_w[ChanW*c +: ChanW] = v_w[c][2*FRAC_BITS +: ChanW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= hand_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && hand_valid) begin
			tex_s1  <= hand_tex;
			fx_s1   <= hand_fx;
			fy_s1   <= hand_fy;
			side_s1 <= hand_side;
		end
		if (en2 && v_s1) begin
			for (int c = 0; c < NumChan; c++) begin
				top_s2[c] <= top_w[c][HW-1:0];
				bot_s2[c] <= bot_w[c][HW-1:0];
			end
			fy_s2   <= fy_s1;
			side_s2 <= side_s1;
		end
		if (en3 && v_s2) begin
			samp_s3 <= texel_t'(samp_w);
			side_s3 <= side_s2;
		end
	end

	assign samp_valid = v_s3;
	assign samp       = samp_s3;
	assign samp_side  = side_s3;

endmodule

>>> rtl/core/bsb_blend.sv
module bsb_blend #(
	parameter int BLEND_SHIFT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  samp_valid,
	output logic                  samp_ready,
	input  bsb_pkg::texel_t       samp,
	input  bsb_pkg::side_t        samp_side,
	input  logic [BLEND_SHIFT:0]  weight,
	input  bsb_pkg::blend_ctl_t   ctl,
	bsb_stream_if.source          results
);
	import bsb_pkg::*;

	localparam int BW = BLEND_SHIFT + 11;

	logic                  res_valid_q;
	result_t               res_data_q;

	logic signed [ChanW:0]  dif [NumChan];
	logic signed [BW-1:0]   acc [NumChan];
	logic [ChanW-1:0]       ch  [NumChan];
	logic [NumChan-1:0]     en;
	result_t                res;

	assign en = {ctl.alpha_en, ctl.chan_en};

	// d*N + (s-d)*w, then drop the weight fraction
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			dif[c] = $signed({1'b0, chan_of(samp, c)}) - $signed({1'b0, chan_of(samp_side.dst, c)});
			acc[c] = $signed({3'b000, chan_of(samp_side.dst, c), {BLEND_SHIFT{1'b0}}})
				+ dif[c] * $signed({1'b0, weight});
			ch[c] = (samp_side.changed && en[c]) ? acc[c][BLEND_SHIFT +: ChanW]
				: chan_of(samp_side.dst, c);
		end
		res.dest_x    = samp_side.dest_x;
		res.dest_y    = samp_side.dest_y;
		res.red_out   = ch[2];
		res.green_out = ch[1];
		res.blue_out  = ch[0];
		res.alpha_out = ch[3];
		res.changed   = samp_side.changed;
	end

	// output register
	assign samp_ready = !res_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (samp_ready) begin
			res_valid_q <= samp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samp_ready && samp_valid) begin
			res_data_q <= res;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_data_q;

endmodule

>>> rtl/core/bilinear_sample_blend.sv
// Bilinear sampler with alpha blend.
// items carries load beats (kind 0) that write one source texel, and sample
// beats (kind 1) that give a 16.8 source position plus a destination pixel
// and its current RGBA. results carries one beat per sample beat with the
// new RGBA and a changed flag; load beats give no result.
// A load or a nearest-texel sample needs one access to the single-port source
// memory and a bilinear sample four, one per neighbor texel; the memory
// returns one texel per cycle unless a stalled lerp pipe freezes the front,
// and the next item is accepted with the last access of the one before.
// From the item register a sample passes through the memory read (one read per
// texel), three lerp stages and the blend into the output register.
// Reset clears all control and loads the register defaults; the source
// store is not cleared and must be loaded before it is sampled.
// When results stalls, the output register holds its beat and the pipeline
// behind it keeps filling; items drops ready once the pipeline is full.
// Configuration writes are taken at any edge with cfg_we high and must
// only occur while no sample is in flight.
module bilinear_sample_blend #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int BLEND_SHIFT = 8,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bsb_stream_if.sink                     items,
	bsb_stream_if.source                   results,
	input  logic                           cfg_we,
	input  logic [bsb_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [bsb_pkg::CfgDataW-1:0]   cfg_data
);
	import bsb_pkg::*;

	localparam int XW        = $clog2(MAX_WIDTH);
	localparam int YW        = $clog2(MAX_HEIGHT);
	localparam int WW        = BLEND_SHIFT + 1;
	localparam int Norm      = 1 << BLEND_SHIFT;
	localparam int WeightRst = (Norm < 256) ? Norm : 256;
	localparam int XLastRst  = (MAX_WIDTH < 256) ? MAX_WIDTH - 1 : 255;
	localparam int YLastRst  = (MAX_HEIGHT < 256) ? MAX_HEIGHT - 1 : 255;

	logic [WW-1:0] weight_q;
	blend_ctl_t    ctl_q;
	logic          interp_q;
	logic [XW-1:0] x_last_q;
	logic [YW-1:0] y_last_q;

	logic                 hand_valid, hand_ready;
	texel_t [3:0]         hand_tex;
	logic [FRAC_BITS-1:0] hand_fx, hand_fy;
	side_t                hand_side;
	logic                 samp_valid, samp_ready;
	texel_t               samp;
	side_t                samp_side;

	// configuration registers, kept in their saturated form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q       <= WW'(WeightRst);
			ctl_q.chan_en  <= 3'b111;
			ctl_q.alpha_en <= 1'b1;
			interp_q       <= 1'b1;
			x_last_q       <= XW'(XLastRst);
			y_last_q       <= YW'(YLastRst);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_BLEND_WEIGHT: begin
					weight_q <= (32'(cfg_data) > Norm) ? WW'(Norm) : WW'(cfg_data);
				end
				REG_CHANNEL_ENABLE: begin
					ctl_q.chan_en <= cfg_data[2:0];
				end
				REG_INTERPOLATE: begin
					interp_q <= cfg_data[0];
				end
				REG_ALPHA_ENABLE: begin
					ctl_q.alpha_en <= cfg_data[0];
				end
				REG_IMAGE_WIDTH: begin
					if (cfg_data == '0) begin
						x_last_q <= '0;
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						x_last_q <= XW'(MAX_WIDTH - 1);
					end else begin
						x_last_q <= XW'(cfg_data - 1'b1);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (cfg_data == '0) begin
						y_last_q <= '0;
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						y_last_q <= YW'(MAX_HEIGHT - 1);
					end else begin
						y_last_q <= YW'(cfg_data - 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	bsb_fetch #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_fetch (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.x_last     (x_last_q),
		.y_last     (y_last_q),
		.interp     (interp_q),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.hand_tex   (hand_tex),
		.hand_fx    (hand_fx),
		.hand_fy    (hand_fy),
		.hand_side  (hand_side)
	);

	bsb_lerp #(
		.FRAC_BITS (FRAC_BITS)
	) u_lerp (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.hand_tex   (hand_tex),
		.hand_fx    (hand_fx),
		.hand_fy    (hand_fy),
		.hand_side  (hand_side),
		.samp_valid (samp_valid),
		.samp_ready (samp_ready),
		.samp       (samp),
		.samp_side  (samp_side)
	);

	bsb_blend #(
		.BLEND_SHIFT (BLEND_SHIFT)
	) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_ready (samp_ready),
		.samp       (samp),
		.samp_side  (samp_side),
		.weight     (weight_q),
		.ctl        (ctl_q),
		.results    (results)
	);

endmodule

>>> rtl/core/bsb_checker.sv
`include "bilinear_sample_blend_defines.svh"

module bsb_checker (
	input logic          clk,
	input logic          arst_n,
	bsb_stream_if.sink   items,
	bsb_stream_if.source results
);
	import bsb_pkg::*;

	// item register, response stage, three lerp/blend stages, output register
	localparam logic [2:0] MaxInFlight = 3'd6;

	logic [2:0] pend_q;
	logic       samp_acc;
	logic       res_acc;

	assign samp_acc = items.valid && items.ready && (items.data.kind == KIND_SAMPLE);
	assign res_acc  = results.valid && results.ready;

	// samples accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + 3'(samp_acc) - 3'(res_acc);
		end
	end

	`BSB_ASSERT_ALWAYS(a_quiet_in_reset, clk, arst_n || !results.valid, "result beat during reset")
	`BSB_ASSERT_NEXT(a_result_held, clk, arst_n, results.valid && !results.ready, results.valid && $stable(results.data), "stalled result beat dropped or changed")
	`BSB_ASSERT_IMPL(a_no_orphan, clk, arst_n, res_acc, pend_q != 3'd0, "result beat without an accepted sample")
	`BSB_ASSERT_ALWAYS(a_in_flight, clk, pend_q <= MaxInFlight, "more samples in flight than the pipeline holds")

endmodule

bind bilinear_sample_blend bsb_checker u_bsb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.items   (items),
	.results (results)
);
